@@ rtl/core/sap_pkg.sv @@
// Package for the SGR attribute parser: parse phases, error codes, SGR code
// numbers, attribute bit positions and the 256-entry xterm palette.
// Depends on nothing; every other file of the block uses it.
`default_nettype none

package sap_pkg;

  // Field widths.
  localparam int unsigned PARAM_W = 16;
  localparam int unsigned RGB_W   = 24;
  localparam int unsigned ATTR_W  = 5;
  localparam int unsigned ERR_W   = 4;
  localparam int unsigned PHASE_W = 3;

  // Configuration register indexes.
  localparam logic CFG_DEFAULT_FG = 1'b0;
  localparam logic CFG_DEFAULT_BG = 1'b1;

  // Reset values of colours and defaults.
  localparam logic [RGB_W-1:0] RESET_FG = 24'hEBEBEB;
  localparam logic [RGB_W-1:0] RESET_BG = 24'h000000;

  // Parse phases.
  localparam logic [PHASE_W-1:0] PH_IDLE  = 3'd0;
  localparam logic [PHASE_W-1:0] PH_TYPE  = 3'd1;
  localparam logic [PHASE_W-1:0] PH_INDEX = 3'd2;
  localparam logic [PHASE_W-1:0] PH_RED   = 3'd3;
  localparam logic [PHASE_W-1:0] PH_GREEN = 3'd4;
  localparam logic [PHASE_W-1:0] PH_BLUE  = 3'd5;
  localparam logic [PHASE_W-1:0] PH_SKIP  = 3'd6;

  // Error codes.
  localparam logic [ERR_W-1:0] ERR_NONE        = 4'd0;
  localparam logic [ERR_W-1:0] ERR_UNKNOWN     = 4'd1;
  localparam logic [ERR_W-1:0] ERR_NO_TYPE     = 4'd2;
  localparam logic [ERR_W-1:0] ERR_BAD_TYPE    = 4'd3;
  localparam logic [ERR_W-1:0] ERR_NO_INDEX    = 4'd4;
  localparam logic [ERR_W-1:0] ERR_INDEX_RANGE = 4'd5;
  localparam logic [ERR_W-1:0] ERR_FEW_RGB     = 4'd6;
  localparam logic [ERR_W-1:0] ERR_RED_RANGE   = 4'd7;
  localparam logic [ERR_W-1:0] ERR_GREEN_RANGE = 4'd8;
  localparam logic [ERR_W-1:0] ERR_BLUE_RANGE  = 4'd9;

  // Attribute bit positions.
  localparam int unsigned ATTR_BOLD      = 0;
  localparam int unsigned ATTR_ITALIC    = 1;
  localparam int unsigned ATTR_UNDERLINE = 2;
  localparam int unsigned ATTR_BLINK     = 3;
  localparam int unsigned ATTR_NEGATIVE  = 4;

  // SGR code numbers.
  localparam logic [PARAM_W-1:0] SGR_RESET        = 16'd0;
  localparam logic [PARAM_W-1:0] SGR_BOLD         = 16'd1;
  localparam logic [PARAM_W-1:0] SGR_FAINT        = 16'd2;
  localparam logic [PARAM_W-1:0] SGR_ITALIC       = 16'd3;
  localparam logic [PARAM_W-1:0] SGR_UNDERLINE    = 16'd4;
  localparam logic [PARAM_W-1:0] SGR_BLINK_SLOW   = 16'd5;
  localparam logic [PARAM_W-1:0] SGR_BLINK_FAST   = 16'd6;
  localparam logic [PARAM_W-1:0] SGR_NEGATIVE     = 16'd7;
  localparam logic [PARAM_W-1:0] SGR_CONCEAL      = 16'd8;
  localparam logic [PARAM_W-1:0] SGR_CROSSED      = 16'd9;
  localparam logic [PARAM_W-1:0] SGR_DBL_UNDER    = 16'd21;
  localparam logic [PARAM_W-1:0] SGR_NO_BOLD      = 16'd22;
  localparam logic [PARAM_W-1:0] SGR_NO_ITALIC    = 16'd23;
  localparam logic [PARAM_W-1:0] SGR_NO_UNDERLINE = 16'd24;
  localparam logic [PARAM_W-1:0] SGR_NO_BLINK     = 16'd25;
  localparam logic [PARAM_W-1:0] SGR_SPACING      = 16'd26;
  localparam logic [PARAM_W-1:0] SGR_NO_NEGATIVE  = 16'd27;
  localparam logic [PARAM_W-1:0] SGR_REVEAL       = 16'd28;
  localparam logic [PARAM_W-1:0] SGR_NO_CROSSED   = 16'd29;
  localparam logic [PARAM_W-1:0] SGR_FG_FIRST     = 16'd30;
  localparam logic [PARAM_W-1:0] SGR_FG_LAST      = 16'd37;
  localparam logic [PARAM_W-1:0] SGR_FG_EXT       = 16'd38;
  localparam logic [PARAM_W-1:0] SGR_FG_DEFAULT   = 16'd39;
  localparam logic [PARAM_W-1:0] SGR_BG_FIRST     = 16'd40;
  localparam logic [PARAM_W-1:0] SGR_BG_LAST      = 16'd47;
  localparam logic [PARAM_W-1:0] SGR_BG_EXT       = 16'd48;
  localparam logic [PARAM_W-1:0] SGR_BG_DEFAULT   = 16'd49;
  localparam logic [PARAM_W-1:0] SGR_FGB_FIRST    = 16'd90;
  localparam logic [PARAM_W-1:0] SGR_FGB_LAST     = 16'd97;
  localparam logic [PARAM_W-1:0] SGR_BGB_FIRST    = 16'd100;
  localparam logic [PARAM_W-1:0] SGR_BGB_LAST     = 16'd107;

  // Extended colour types, component limit and low-index limit.
  localparam logic [PARAM_W-1:0] EXT_TYPE_INDEX = 16'd5;
  localparam logic [PARAM_W-1:0] EXT_TYPE_RGB   = 16'd2;
  localparam logic [PARAM_W-1:0] COMP_MAX       = 16'd255;
  localparam logic [PARAM_W-1:0] LOW_INDEX_LIM  = 16'd8;

  typedef logic [RGB_W-1:0] pal_table_t [256];

  localparam logic [RGB_W-1:0] BASE16 [16] = '{
    24'h000000, 24'hD20000, 24'h00D200, 24'hD2D200,
    24'h0000F0, 24'hD200D2, 24'h00D2D2, 24'hEBEBEB,
    24'h7F7F7F, 24'hFF0000, 24'h00FF00, 24'hFFFF00,
    24'h5C5CFF, 24'hFF00FF, 24'h00FFFF, 24'hFFFFFF
  };

  // Builds the xterm palette at elaboration: 16 base colours, a 6x6x6
  // cube and a 24-step gray ramp.
  function automatic pal_table_t build_palette();
    pal_table_t  tbl;
    logic [7:0]  lvl [6];
    logic [7:0]  gray;
    int          idx;
    for (int k = 0; k < 6; k++) begin
      lvl[k] = (k == 0) ? 8'd0 : 8'(32'h5f + 32'h28 * (k - 1));
    end
    for (int i = 0; i < 16; i++) begin
      tbl[i] = BASE16[i];
    end
    for (int r = 0; r < 6; r++) begin
      for (int g = 0; g < 6; g++) begin
        for (int b = 0; b < 6; b++) begin
          idx = 16 + 36 * r + 6 * g + b;
          tbl[idx] = {lvl[r], lvl[g], lvl[b]};
        end
      end
    end
    for (int i = 0; i < 24; i++) begin
      gray = 8'(8 + 10 * i);
      tbl[232 + i] = {gray, gray, gray};
    end
    return tbl;
  endfunction

  localparam pal_table_t PALETTE = build_palette();

endpackage

`default_nettype wire

@@ rtl/core/sap_channels.sv @@
// Valid/ready channel interfaces for the SGR attribute parser: the parameter
// input channel and the rendition result channel.
// Depends on sap_pkg for field widths.
`default_nettype none

interface sap_in_if;
  logic                        valid;
  logic                        ready;
  logic [sap_pkg::PARAM_W-1:0] param_value;
  logic                        is_last;

  modport source (output valid, output param_value, output is_last, input ready);
  modport sink (input valid, input param_value, input is_last, output ready);
endinterface

interface sap_out_if;
  logic                      valid;
  logic                      ready;
  logic [sap_pkg::RGB_W-1:0] fg_out;
  logic [sap_pkg::RGB_W-1:0] bg_out;
  logic [sap_pkg::ATTR_W-1:0] attr_out;
  logic [sap_pkg::ERR_W-1:0] error_code;

  modport source (output valid, output fg_out, output bg_out, output attr_out,
                  output error_code, input ready);
  modport sink (input valid, input fg_out, input bg_out, input attr_out,
                input error_code, output ready);
endinterface

`default_nettype wire

@@ rtl/core/sgr_attribute_parser_unit.sv @@
// Top level of the SGR attribute parser: input register, decode and palette
// lookup, rendition state and result register.
// Depends on sap_pkg and the channel interfaces in sap_channels.sv.
//
// Usage: the input channel carries the numeric parameters of one SGR escape
// sequence, one per transfer, with is_last set on the final one. Only the
// final parameter produces a result transfer, holding the current foreground,
// background, attribute flags and the error code of that sequence. Colours
// and attributes persist from one sequence to the next.
// Result path: a final parameter moves from the input register into the result
// register once the result slot is free, and its result is offered from there.
// Throughput: one parameter per cycle while no final parameter waits for the
// result slot; the decode and a single lookup into a constant 256-entry
// palette sit between the input and result registers.
// Configuration: cfg_wr_en writes cfg_wr_data into the default foreground
// (index 0) or background (index 1) register; write only while idle.
// Reset: synchronous, active low; colours go to their reset defaults,
// attributes clear, parsing returns to idle and both registers hold nothing.
// Stall: while a result waits, non-final parameters keep flowing; a final
// parameter waits in the input register until the result slot frees.
`default_nettype none

module sgr_attribute_parser_unit (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  sap_in_if.sink                           in_ch,
  sap_out_if.source                        out_ch,
  input  wire logic                        cfg_wr_en,
  input  wire logic                        cfg_index,
  input  wire logic [sap_pkg::RGB_W-1:0]   cfg_wr_data
);

  // Configuration registers.
  logic [sap_pkg::RGB_W-1:0] dflt_fg_r;
  logic [sap_pkg::RGB_W-1:0] dflt_bg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dflt_fg_r <= sap_pkg::RESET_FG;
      dflt_bg_r <= sap_pkg::RESET_BG;
    end else if (cfg_wr_en) begin
      if (cfg_index == sap_pkg::CFG_DEFAULT_FG) begin
        dflt_fg_r <= cfg_wr_data;
      end else begin
        dflt_bg_r <= cfg_wr_data;
      end
    end
  end

  // Input register stage.
  logic                        s1_valid_r;
  logic [sap_pkg::PARAM_W-1:0] s1_param_r;
  logic                        s1_last_r;
  logic                        s1_adv;
  logic                        out_free;

  assign out_free    = !out_ch.valid || out_ch.ready;
  assign s1_adv      = s1_valid_r && (!s1_last_r || out_free);
  assign in_ch.ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_param_r <= in_ch.param_value;
      s1_last_r  <= in_ch.is_last;
    end
  end

  // Rendition and parse state.
  logic [sap_pkg::RGB_W-1:0]   fg_r, fg_nxt;
  logic [sap_pkg::RGB_W-1:0]   bg_r, bg_nxt;
  logic [sap_pkg::ATTR_W-1:0]  attr_r, attr_nxt;
  logic [sap_pkg::PHASE_W-1:0] phase_r, phase_nxt;
  logic                        tgt_fg_r, tgt_fg_nxt;
  logic [7:0]                  red_r, red_nxt;
  logic [7:0]                  green_r, green_nxt;
  logic [sap_pkg::ERR_W-1:0]   perr_r, perr_nxt;
  logic [sap_pkg::ERR_W-1:0]   err;
  logic [sap_pkg::ERR_W-1:0]   err_out;
  logic [7:0]                  pal_idx;
  logic [sap_pkg::RGB_W-1:0]   pal_rgb;
  logic [sap_pkg::PARAM_W-1:0] p;
  logic                        bold;

  assign p       = s1_param_r;
  assign bold    = attr_r[sap_pkg::ATTR_BOLD];
  assign pal_rgb = sap_pkg::PALETTE[pal_idx];

  // Palette index: only one lookup is ever needed per parameter.
  always_comb begin
    pal_idx = p[7:0];
    if (phase_r == sap_pkg::PH_INDEX) begin
      if (tgt_fg_r && bold && p < sap_pkg::LOW_INDEX_LIM) begin
        pal_idx = p[7:0] + 8'd8;
      end
    end else begin
      case (p) inside
        [sap_pkg::SGR_FG_FIRST:sap_pkg::SGR_FG_LAST]:
          pal_idx = {4'd0, bold, 3'(p[7:0] - 8'(sap_pkg::SGR_FG_FIRST))};
        [sap_pkg::SGR_BG_FIRST:sap_pkg::SGR_BG_LAST]:
          pal_idx = {5'd0, 3'(p[7:0] - 8'(sap_pkg::SGR_BG_FIRST))};
        [sap_pkg::SGR_FGB_FIRST:sap_pkg::SGR_FGB_LAST]:
          pal_idx = {5'd1, 3'(p[7:0] - 8'(sap_pkg::SGR_FGB_FIRST))};
        [sap_pkg::SGR_BGB_FIRST:sap_pkg::SGR_BGB_LAST]:
          pal_idx = {5'd1, 3'(p[7:0] - 8'(sap_pkg::SGR_BGB_FIRST))};
        default: pal_idx = p[7:0];
      endcase
    end
  end

  // Decode of one parameter against the current phase.
  always_comb begin
    fg_nxt     = fg_r;
    bg_nxt     = bg_r;
    attr_nxt   = attr_r;
    phase_nxt  = phase_r;
    tgt_fg_nxt = tgt_fg_r;
    red_nxt    = red_r;
    green_nxt  = green_r;
    perr_nxt   = perr_r;
    err        = sap_pkg::ERR_NONE;

    case (phase_r)
      sap_pkg::PH_IDLE: begin
        case (p) inside
          sap_pkg::SGR_RESET: begin
            fg_nxt   = dflt_fg_r;
            bg_nxt   = dflt_bg_r;
            attr_nxt = '0;
          end
          sap_pkg::SGR_BOLD:      attr_nxt[sap_pkg::ATTR_BOLD]      = 1'b1;
          sap_pkg::SGR_ITALIC:    attr_nxt[sap_pkg::ATTR_ITALIC]    = 1'b1;
          sap_pkg::SGR_UNDERLINE: attr_nxt[sap_pkg::ATTR_UNDERLINE] = 1'b1;
          sap_pkg::SGR_BLINK_SLOW, sap_pkg::SGR_BLINK_FAST:
            attr_nxt[sap_pkg::ATTR_BLINK] = 1'b1;
          sap_pkg::SGR_NEGATIVE:     attr_nxt[sap_pkg::ATTR_NEGATIVE]  = 1'b1;
          sap_pkg::SGR_NO_BOLD:      attr_nxt[sap_pkg::ATTR_BOLD]      = 1'b0;
          sap_pkg::SGR_NO_ITALIC:    attr_nxt[sap_pkg::ATTR_ITALIC]    = 1'b0;
          sap_pkg::SGR_NO_UNDERLINE: attr_nxt[sap_pkg::ATTR_UNDERLINE] = 1'b0;
          sap_pkg::SGR_NO_BLINK, sap_pkg::SGR_SPACING:
            attr_nxt[sap_pkg::ATTR_BLINK] = 1'b0;
          sap_pkg::SGR_NO_NEGATIVE:  attr_nxt[sap_pkg::ATTR_NEGATIVE]  = 1'b0;
          sap_pkg::SGR_FAINT, sap_pkg::SGR_CONCEAL, sap_pkg::SGR_CROSSED,
          sap_pkg::SGR_DBL_UNDER, sap_pkg::SGR_REVEAL, sap_pkg::SGR_NO_CROSSED: begin
            attr_nxt = attr_r;
          end
          sap_pkg::SGR_FG_DEFAULT: fg_nxt = dflt_fg_r;
          sap_pkg::SGR_BG_DEFAULT: bg_nxt = dflt_bg_r;
          sap_pkg::SGR_FG_EXT, sap_pkg::SGR_BG_EXT: begin
            tgt_fg_nxt = (p == sap_pkg::SGR_FG_EXT);
            phase_nxt  = sap_pkg::PH_TYPE;
            if (s1_last_r) begin
              err = sap_pkg::ERR_NO_TYPE;
            end
          end
          [sap_pkg::SGR_FG_FIRST:sap_pkg::SGR_FG_LAST],
          [sap_pkg::SGR_FGB_FIRST:sap_pkg::SGR_FGB_LAST]: fg_nxt = pal_rgb;
          [sap_pkg::SGR_BG_FIRST:sap_pkg::SGR_BG_LAST],
          [sap_pkg::SGR_BGB_FIRST:sap_pkg::SGR_BGB_LAST]: bg_nxt = pal_rgb;
          default: err = sap_pkg::ERR_UNKNOWN;
        endcase
      end
      sap_pkg::PH_TYPE: begin
        if (p == sap_pkg::EXT_TYPE_INDEX) begin
          phase_nxt = sap_pkg::PH_INDEX;
          if (s1_last_r) begin
            err = sap_pkg::ERR_NO_INDEX;
          end
        end else if (p == sap_pkg::EXT_TYPE_RGB) begin
          phase_nxt = sap_pkg::PH_RED;
          if (s1_last_r) begin
            err = sap_pkg::ERR_FEW_RGB;
          end
        end else begin
          err = sap_pkg::ERR_BAD_TYPE;
        end
      end
      sap_pkg::PH_INDEX: begin
        phase_nxt = sap_pkg::PH_IDLE;
        if (p > sap_pkg::COMP_MAX) begin
          err = sap_pkg::ERR_INDEX_RANGE;
        end else if (tgt_fg_r) begin
          fg_nxt = pal_rgb;
        end else begin
          bg_nxt = pal_rgb;
        end
      end
      sap_pkg::PH_RED: begin
        if (s1_last_r) begin
          err = sap_pkg::ERR_FEW_RGB;
        end else begin
          red_nxt   = p[7:0];
          perr_nxt  = (p > sap_pkg::COMP_MAX) ? sap_pkg::ERR_RED_RANGE : sap_pkg::ERR_NONE;
          phase_nxt = sap_pkg::PH_GREEN;
        end
      end
      sap_pkg::PH_GREEN: begin
        if (s1_last_r) begin
          err = sap_pkg::ERR_FEW_RGB;
        end else begin
          green_nxt = p[7:0];
          if (perr_r == sap_pkg::ERR_NONE && p > sap_pkg::COMP_MAX) begin
            perr_nxt = sap_pkg::ERR_GREEN_RANGE;
          end
          phase_nxt = sap_pkg::PH_BLUE;
        end
      end
      sap_pkg::PH_BLUE: begin
        phase_nxt = sap_pkg::PH_IDLE;
        if (perr_r != sap_pkg::ERR_NONE) begin
          err = perr_r;
        end else if (p > sap_pkg::COMP_MAX) begin
          err = sap_pkg::ERR_BLUE_RANGE;
        end else if (tgt_fg_r) begin
          fg_nxt = {red_r, green_r, p[7:0]};
        end else begin
          bg_nxt = {red_r, green_r, p[7:0]};
        end
      end
      // Skipping, and the unused phase code, ignore the parameter.
      default: begin
        phase_nxt = phase_r;
      end
    endcase

    // First error of the sequence: hold it and skip the rest.
    if (err != sap_pkg::ERR_NONE) begin
      perr_nxt  = err;
      phase_nxt = sap_pkg::PH_SKIP;
    end

    err_out = (phase_nxt >= sap_pkg::PH_SKIP) ? perr_nxt : sap_pkg::ERR_NONE;

    // End of sequence returns the parser to idle.
    if (s1_last_r) begin
      phase_nxt  = sap_pkg::PH_IDLE;
      perr_nxt   = sap_pkg::ERR_NONE;
      tgt_fg_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_r     <= sap_pkg::RESET_FG;
      bg_r     <= sap_pkg::RESET_BG;
      attr_r   <= '0;
      phase_r  <= sap_pkg::PH_IDLE;
      tgt_fg_r <= 1'b0;
      red_r    <= '0;
      green_r  <= '0;
      perr_r   <= sap_pkg::ERR_NONE;
    end else if (s1_adv) begin
      fg_r     <= fg_nxt;
      bg_r     <= bg_nxt;
      attr_r   <= attr_nxt;
      phase_r  <= phase_nxt;
      tgt_fg_r <= tgt_fg_nxt;
      red_r    <= red_nxt;
      green_r  <= green_nxt;
      perr_r   <= perr_nxt;
    end
  end

  // Result register.
  logic                       out_valid_r;
  logic [sap_pkg::RGB_W-1:0]  out_fg_r;
  logic [sap_pkg::RGB_W-1:0]  out_bg_r;
  logic [sap_pkg::ATTR_W-1:0] out_attr_r;
  logic [sap_pkg::ERR_W-1:0]  out_err_r;
  logic                       res_load;

  assign res_load = s1_adv && s1_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_fg_r   <= fg_nxt;
      out_bg_r   <= bg_nxt;
      out_attr_r <= attr_nxt;
      out_err_r  <= err_out;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.fg_out     = out_fg_r;
  assign out_ch.bg_out     = out_bg_r;
  assign out_ch.attr_out   = out_attr_r;
  assign out_ch.error_code = out_err_r;

  // A final parameter always leaves the parser idle with no held error.
  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |=> (phase_r == sap_pkg::PH_IDLE && perr_r == sap_pkg::ERR_NONE && !tgt_fg_r))
    else $error("parser not idle after final parameter");

  // The blue component phase is entered only from the green one.
  a_blue_after_green: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(phase_r == sap_pkg::PH_BLUE) |-> $past(phase_r) == sap_pkg::PH_GREEN)
    else $error("blue phase entered out of order");

  // A result can never be overwritten before it has been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |-> !res_load)
    else $error("result register overwritten while stalled");

endmodule

`default_nettype wire
